// ===== hdl/clt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Types, codes and character constants shared by the configuration line
// tokenizer controller, datapath and top level.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_NUL     = 8'h00;

	localparam logic [1:0] ROLE_NAME   = 2'd0;
	localparam logic [1:0] ROLE_VALUE  = 2'd1;
	localparam logic [1:0] ROLE_STATUS = 2'd2;

	localparam logic [1:0] LS_NAME_VALUE = 2'd0;
	localparam logic [1:0] LS_NAME_ONLY  = 2'd1;
	localparam logic [1:0] LS_NO_PARAM   = 2'd2;
	localparam logic [1:0] LS_OVERFLOW   = 2'd3;

	// Position within the line.
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NAME,
		PH_GAP,
		PH_VALUE,
		PH_CMT_EMPTY,
		PH_CMT_NAMED
	} phase_t;

	// Sequencer states, one pass per accepted byte.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ESC,
		ST_CLASSIFY,
		ST_FLUSH,
		ST_DELIVER,
		ST_END,
		ST_STATUS
	} ctrl_state_t;

	// Source of an emitted result.
	typedef enum logic [1:0] {
		EM_CHAR,
		EM_BSLASH,
		EM_BLANK,
		EM_STATUS
	} emit_sel_t;

	typedef struct packed {
		logic      capture;
		logic      emit;
		emit_sel_t emit_sel;
		logic [1:0] role;
		logic      phase_ld;
		phase_t    phase_nxt;
		logic      set_held;
		logic      clr_held;
		logic      push_blank;
		logic      set_ovf;
		logic      set_value;
		logic      clr_count;
		logic      inc_idx;
		logic      line_clear;
	} clt_cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   held_bs;
		logic   is_hash;
		logic   is_blank;
		logic   is_bslash;
		logic   skip;
		logic   line_end;
		logic   count_zero;
		logic   count_full;
		logic   flush_last;
		logic   out_free;
	} clt_stat_t;

	function automatic logic [1:0] cur_role(input phase_t ph);
		return (ph == PH_NAME) ? ROLE_NAME : ROLE_VALUE;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/clt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_datapath
// Holds the captured byte, line state, the held blank store and the output
// register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module clt_datapath import clt_pkg::*; #(
	parameter int BLANK_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire clt_cmd_t   cmd,
	output clt_stat_t       stat,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      out_role,
	output logic [1:0]      out_status,
	output logic            out_last
);

	localparam int CW = $clog2(BLANK_DEPTH + 1);
	localparam int IW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

	logic [7:0]    char_q;
	logic          end_q;
	phase_t        phase_q;
	logic          held_q;
	logic          value_q;
	logic          ovf_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          kinds_q [BLANK_DEPTH];

	logic          valid_q;
	logic [7:0]    obyte_q;
	logic [1:0]    orole_q;
	logic [1:0]    ostat_q;
	logic          olast_q;

	logic          kind_rd;
	logic [7:0]    emit_byte;
	logic [1:0]    line_stat;

	// Payload capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= in_byte;
			end_q  <= in_last;
		end
	end

	// Held blank store: a tab is stored as one, a space as zero.
	always_ff @(posedge clk) begin
		if (cmd.push_blank) begin
			kinds_q[count_q[IW-1:0]] <= (char_q == CH_TAB);
		end
	end

	assign kind_rd = kinds_q[idx_q[IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			held_q  <= 1'b0;
			value_q <= 1'b0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
		end else if (cmd.line_clear) begin
			phase_q <= PH_LEAD;
			held_q  <= 1'b0;
			value_q <= 1'b0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.phase_ld) begin
				phase_q <= cmd.phase_nxt;
			end
			if (cmd.set_held) begin
				held_q <= 1'b1;
			end else if (cmd.clr_held) begin
				held_q <= 1'b0;
			end
			if (cmd.set_value) begin
				value_q <= 1'b1;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.clr_count) begin
				count_q <= '0;
				idx_q   <= '0;
			end else begin
				if (cmd.push_blank) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.inc_idx) begin
					idx_q <= idx_q + CW'(1);
				end
			end
		end
	end

	always_comb begin
		if (ovf_q) begin
			line_stat = LS_OVERFLOW;
		end else if (phase_q == PH_LEAD || phase_q == PH_CMT_EMPTY) begin
			line_stat = LS_NO_PARAM;
		end else if (value_q) begin
			line_stat = LS_NAME_VALUE;
		end else begin
			line_stat = LS_NAME_ONLY;
		end
	end

	always_comb begin
		unique case (cmd.emit_sel)
			EM_CHAR:   emit_byte = char_q;
			EM_BSLASH: emit_byte = CH_BSLASH;
			EM_BLANK:  emit_byte = kind_rd ? CH_TAB : CH_SPACE;
			EM_STATUS: emit_byte = CH_NUL;
			default:   emit_byte = CH_NUL;
		endcase
	end

	// Output register: a result waits here while the next step proceeds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			obyte_q <= emit_byte;
			orole_q <= cmd.role;
			ostat_q <= (cmd.emit_sel == EM_STATUS) ? line_stat : LS_NAME_VALUE;
			olast_q <= (cmd.emit_sel == EM_STATUS);
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = obyte_q;
	assign out_role   = orole_q;
	assign out_status = ostat_q;
	assign out_last   = olast_q;

	assign stat.phase      = phase_q;
	assign stat.held_bs    = held_q;
	assign stat.is_hash    = (char_q == CH_HASH);
	assign stat.is_blank   = (char_q == CH_SPACE) || (char_q == CH_TAB);
	assign stat.is_bslash  = (char_q == CH_BSLASH);
	assign stat.skip       = end_q && (char_q == CH_NEWLINE);
	assign stat.line_end   = end_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = (count_q == CW'(BLANK_DEPTH));
	assign stat.flush_last = (idx_q == count_q - CW'(1));
	assign stat.out_free   = !valid_q || out_ready;

endmodule
`default_nettype wire

// ===== hdl/clt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_ctrl
// Sequencer that walks each accepted byte through escape handling,
// classification, blank flushing, delivery and end of line.
// ----------------------------------------------------------------------------
module clt_ctrl import clt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire clt_stat_t stat,
	output clt_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        in_cmt;

	assign in_cmt = (stat.phase == PH_CMT_EMPTY) || (stat.phase == PH_CMT_NAMED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.emit_sel  = EM_CHAR;
		cmd.phase_nxt = PH_LEAD;
		state_nxt = state_q;
		in_ready  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_ESC;
				end
			end

			// A held backslash is resolved by the byte that follows it.
			ST_ESC: begin
				if (stat.skip || in_cmt || !stat.held_bs) begin
					state_nxt = ST_CLASSIFY;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = stat.is_hash ? EM_CHAR : EM_BSLASH;
					cmd.role     = cur_role(stat.phase);
					cmd.clr_held = 1'b1;
					state_nxt    = stat.is_hash ? ST_END : ST_CLASSIFY;
				end
			end

			ST_CLASSIFY: begin
				if (stat.skip || in_cmt) begin
					state_nxt = ST_END;
				end else if (stat.is_hash) begin
					cmd.clr_count = 1'b1;
					cmd.phase_ld  = 1'b1;
					cmd.phase_nxt = (stat.phase == PH_LEAD) ? PH_CMT_EMPTY : PH_CMT_NAMED;
					state_nxt     = ST_END;
				end else begin
					unique case (stat.phase)
						PH_LEAD: begin
							if (stat.is_blank) begin
								state_nxt = ST_END;
							end else begin
								cmd.phase_ld  = 1'b1;
								cmd.phase_nxt = PH_NAME;
								state_nxt     = ST_DELIVER;
							end
						end
						PH_NAME: begin
							if (stat.is_blank) begin
								cmd.phase_ld  = 1'b1;
								cmd.phase_nxt = PH_GAP;
								state_nxt     = ST_END;
							end else begin
								state_nxt = ST_DELIVER;
							end
						end
						PH_GAP: begin
							if (stat.is_blank) begin
								state_nxt = ST_END;
							end else begin
								cmd.phase_ld  = 1'b1;
								cmd.phase_nxt = PH_VALUE;
								cmd.set_value = 1'b1;
								state_nxt     = ST_DELIVER;
							end
						end
						default: begin
							if (stat.is_blank) begin
								if (stat.count_full) begin
									cmd.set_ovf = 1'b1;
								end else begin
									cmd.push_blank = 1'b1;
								end
								state_nxt = ST_END;
							end else if (stat.count_zero) begin
								state_nxt = ST_DELIVER;
							end else begin
								state_nxt = ST_FLUSH;
							end
						end
					endcase
				end
			end

			// Held blanks go out one per cycle ahead of the non-blank, while the output register is free.
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_BLANK;
					cmd.role     = ROLE_VALUE;
					if (stat.flush_last) begin
						cmd.clr_count = 1'b1;
						state_nxt     = ST_DELIVER;
					end else begin
						cmd.inc_idx = 1'b1;
					end
				end
			end

			ST_DELIVER: begin
				if (stat.is_bslash) begin
					cmd.set_held = 1'b1;
					state_nxt    = ST_END;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_CHAR;
					cmd.role     = cur_role(stat.phase);
					state_nxt    = ST_END;
				end
			end

			ST_END: begin
				if (!stat.line_end) begin
					state_nxt = ST_IDLE;
				end else if (!stat.held_bs) begin
					state_nxt = ST_STATUS;
				end else if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_BSLASH;
					cmd.role     = cur_role(stat.phase);
					cmd.clr_held = 1'b1;
					state_nxt    = ST_STATUS;
				end
			end

			ST_STATUS: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = EM_STATUS;
					cmd.role       = ROLE_STATUS;
					cmd.line_clear = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end

			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/config_line_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// config_line_tokenizer
// Splits a configuration line, one byte per request, into name and value
// bytes and closes each line with a status item.
// ----------------------------------------------------------------------------
// The block reads one line a byte at a time on the slave stream, with tlast
// marking the final byte, and produces tagged bytes on the master stream.
// Leading blanks are skipped, the name runs to the first space or tab, the
// blanks that follow are skipped, and the rest of the line is the value with
// trailing blanks trimmed. An unescaped hash starts a comment; a backslash
// directly before a hash is dropped and the hash kept. A newline on the
// final byte is stripped. Each line ends with a status item (tlast high)
// that reports name and value, name only, no parameter, or blank overflow.
// Blanks inside the value are held in a store of BLANK_DEPTH entries and
// sent only once a later non-blank arrives; a blank that finds the store
// full is dropped and the line is marked as overflowed. Each accepted byte
// is walked by a sequencer through capture, escape check, classification,
// delivery and end of line, and a new request is taken only once that
// pass is over. A blank, a hash that opens a comment or a byte inside a
// comment skips delivery, and the hash of an escape goes out straight
// from the escape check and skips classification and delivery. Held
// blanks are flushed ahead of delivery, and the final byte of a line adds
// a status step; a backslash still pending at that point goes out in the
// end-of-line step. Results leave through a single output register, so
// the next step continues while a result waits to be taken, and a stalled
// master side holds the sequencer only when a new result is due.
// ----------------------------------------------------------------------------
module config_line_tokenizer import clt_pkg::*; #(
	parameter int BLANK_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_byte
	input  wire logic       s_tlast,   // line_end
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [3:0]      m_tuser,   // [1:0] role, [3:2] line_status
	output logic            m_tlast    // last
);

	clt_cmd_t   cmd;
	clt_stat_t  stat;
	logic [1:0] role;
	logic [1:0] line_status;

	// Sequencer: decides what each cycle of a byte's pass does.
	clt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: line state, blank store and the output register.
	clt_datapath #(
		.BLANK_DEPTH (BLANK_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_role   (role),
		.out_status (line_status),
		.out_last   (m_tlast)
	);

	assign m_tuser = {line_status, role};

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the configuration line tokenizer.
// ----------------------------------------------------------------------------
// Lines of bytes are fed on the slave stream, one request per byte with
// tlast on the final byte. A scoreboard keeps its own model of the
// tokenizer: each accepted request is turned into the tagged bytes and the
// status item that it should cause. Every result taken from the master
// stream is compared with the oldest of those. A short directed run covers
// blanks, escaped hashes, a trailing backslash, newlines, the extreme byte
// values and comment lines. Then four phases of random lines follow, with
// no idling, an idle sender, a stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module tb import clt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLANK_DEPTH = 32;
	localparam int PHASE_ITEMS = 90;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;

	// One result of the tokenizer: a tagged byte or the line status item.
	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] role;
		logic [1:0] status;
		logic       last;
	} token_t;

	// Scoreboard: tracks the tokenizer state, queues the results that each
	// accepted request should cause, and checks the results as they arrive.
	class token_board;
		phase_t      ph;
		bit          held_bs;
		bit          blank_tab[BLANK_DEPTH];
		int unsigned held_n;
		bit          has_value;
		bit          ovf;
		token_t      pending_tokens[$];
		int unsigned errors;

		function new();
			ph        = PH_LEAD;
			held_bs   = 0;
			held_n    = 0;
			has_value = 0;
			ovf       = 0;
			errors    = 0;
		endfunction

		function logic [1:0] role_now();
			return (ph == PH_NAME) ? ROLE_NAME : ROLE_VALUE;
		endfunction

		function void push_token(logic [7:0] c, logic [1:0] r, logic [1:0] s, logic l);
			token_t t;
			t.ch     = c;
			t.role   = r;
			t.status = s;
			t.last   = l;
			pending_tokens.push_back(t);
		endfunction

		// A backslash is held back until the next byte shows whether it
		// escapes a hash; anything else goes out at once.
		function void pass_char(logic [7:0] c);
			if (c == CH_BSLASH) begin
				held_bs = 1;
			end else begin
				push_token(c, role_now(), LS_NAME_VALUE, 1'b0);
			end
		endfunction

		function void tokenize_byte(logic [7:0] c);
			bit blank;
			if (ph == PH_CMT_EMPTY || ph == PH_CMT_NAMED)
				return;
			if (held_bs) begin
				held_bs = 0;
				if (c == CH_HASH) begin
					push_token(CH_HASH, role_now(), LS_NAME_VALUE, 1'b0);
					return;
				end
				push_token(CH_BSLASH, role_now(), LS_NAME_VALUE, 1'b0);
			end
			if (c == CH_HASH) begin
				held_n = 0;
				ph = (ph == PH_LEAD) ? PH_CMT_EMPTY : PH_CMT_NAMED;
				return;
			end
			blank = (c == CH_SPACE || c == CH_TAB);
			case (ph)
				PH_LEAD: begin
					if (!blank) begin
						ph = PH_NAME;
						pass_char(c);
					end
				end
				PH_NAME: begin
					if (blank)
						ph = PH_GAP;
					else
						pass_char(c);
				end
				PH_GAP: begin
					if (!blank) begin
						ph = PH_VALUE;
						has_value = 1;
						pass_char(c);
					end
				end
				default: begin
					if (blank) begin
						if (held_n < BLANK_DEPTH) begin
							blank_tab[held_n] = (c == CH_TAB);
							held_n++;
						end else begin
							ovf = 1;
						end
					end else begin
						for (int i = 0; i < held_n; i++)
							push_token(blank_tab[i] ? CH_TAB : CH_SPACE, ROLE_VALUE,
								LS_NAME_VALUE, 1'b0);
						held_n = 0;
						pass_char(c);
					end
				end
			endcase
		endfunction

		function void note_request(logic [7:0] c, logic line_end);
			logic [1:0] s;
			if (!(line_end && c == CH_NEWLINE))
				tokenize_byte(c);
			if (!line_end)
				return;
			if (held_bs)
				push_token(CH_BSLASH, role_now(), LS_NAME_VALUE, 1'b0);
			if (ovf)
				s = LS_OVERFLOW;
			else if (ph == PH_LEAD || ph == PH_CMT_EMPTY)
				s = LS_NO_PARAM;
			else
				s = has_value ? LS_NAME_VALUE : LS_NAME_ONLY;
			push_token(CH_NUL, ROLE_STATUS, s, 1'b1);
			ph        = PH_LEAD;
			held_bs   = 0;
			held_n    = 0;
			has_value = 0;
			ovf       = 0;
		endfunction

		task report_mismatch(string what, token_t got, token_t want);
			errors++;
			if (errors <= 30)
				$display("mismatch: %0s, got byte %h role %0d status %0d last %0d,",
					what, got.ch, got.role, got.status, got.last,
					" wanted byte %h role %0d status %0d last %0d",
					want.ch, want.role, want.status, want.last);
		endtask

		task check_result(logic [7:0] c, logic [3:0] u, logic l);
			token_t got;
			token_t want;
			got.ch     = c;
			got.role   = u[1:0];
			got.status = u[3:2];
			got.last   = l;
			if (pending_tokens.size() == 0) begin
				want = '0;
				report_mismatch("unexpected result", got, want);
			end else begin
				want = pending_tokens.pop_front();
				if (got.ch != want.ch)
					report_mismatch("byte", got, want);
				else if (got.role != want.role)
					report_mismatch("role", got, want);
				else if (got.status != want.status)
					report_mismatch("line status", got, want);
				else if (got.last != want.last)
					report_mismatch("last flag", got, want);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [3:0] m_tuser;
	logic       m_tlast;

	token_board  board;
	logic [7:0]  line_q[$];
	int unsigned sent_count;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;

	config_line_tokenizer #(
		.BLANK_DEPTH(BLANK_DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #4 clk = ~clk;

	// Watchdog: a hung block or a lost handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver stalls at random, with the rate set by the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Results are sampled at the edge where the handshake completes.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Offers one byte, idling first at the current rate, and returns once the
	// request has been taken. tvalid stays high so back-to-back requests need
	// no extra assignment in the same step.
	task send_char(input logic [7:0] c, input logic line_end);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= line_end;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(c, line_end);
		sent_count++;
	endtask

	task send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_char(line_q[i], i == line_q.size() - 1);
	endtask

	// Printable, non-blank byte that carries no special meaning.
	function automatic logic [7:0] pick_text();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (c == CH_HASH || c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
	endfunction

	function automatic void add_blanks(int n);
		repeat (n) line_q.push_back(pick_blank());
	endfunction

	// A word with the odd escaped hash or lone backslash mixed in.
	function automatic void add_word(int len);
		repeat (len) begin
			if ($urandom_range(0, 9) == 0) begin
				line_q.push_back(CH_BSLASH);
				line_q.push_back(CH_HASH);
			end else if ($urandom_range(0, 15) == 0) begin
				line_q.push_back(CH_BSLASH);
			end else begin
				line_q.push_back(pick_text());
			end
		end
	endfunction

	// Builds one random line. Most lines are well formed, so that the value
	// phase and its blank store get exercised; the rest are noise, comment
	// lines, blank lines and lines cut short after a backslash. A forced long
	// run puts one blank run around the depth of the blank store.
	function automatic void build_line(bit force_long);
		int kind;
		int words;
		bit long_left;
		line_q.delete();
		long_left = force_long;
		kind = force_long ? 0 : $urandom_range(0, 9);
		if (kind <= 5) begin
			add_blanks($urandom_range(0, 3));
			add_word($urandom_range(1, 6));
			if (kind != 5) begin
				add_blanks($urandom_range(1, 3));
				words = $urandom_range(1, 4);
				for (int w = 0; w < words; w++) begin
					add_word($urandom_range(1, 5));
					if (w < words - 1) begin
						if (long_left || $urandom_range(0, 7) == 0) begin
							add_blanks($urandom_range(BLANK_DEPTH - 2, BLANK_DEPTH + 4));
							long_left = 0;
						end else begin
							add_blanks($urandom_range(1, 4));
						end
					end
				end
				if (long_left)
					add_blanks(BLANK_DEPTH + 2);
			end
			add_blanks($urandom_range(0, 3));
			if ($urandom_range(0, 3) == 0) begin
				line_q.push_back(CH_HASH);
				add_word($urandom_range(1, 4));
			end
			if ($urandom_range(0, 2) == 0)
				line_q.push_back(CH_NEWLINE);
		end else if (kind == 6) begin
			repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(1, 255)));
		end else if (kind == 7) begin
			add_blanks($urandom_range(0, 2));
			line_q.push_back(CH_HASH);
			add_word($urandom_range(0, 4));
		end else if (kind == 8) begin
			add_blanks($urandom_range(0, 4));
			line_q.push_back(CH_NEWLINE);
		end else begin
			add_word($urandom_range(1, 3));
			if ($urandom_range(0, 1))
				add_blanks($urandom_range(1, 2));
			line_q.push_back(CH_BSLASH);
		end
	endfunction

	task run_phase(input int unsigned idle_pct, input int unsigned stall);
		int unsigned start;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		start         = sent_count;
		build_line(1'b1);
		send_line();
		while (sent_count - start < PHASE_ITEMS) begin
			build_line(1'b0);
			send_line();
		end
		// Hold off the sender until every result of this phase has arrived.
		s_tvalid <= 1'b0;
		while (board.pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		board = new();
		sent_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Leading blanks, an escaped hash in the name, a gap of mixed blanks,
		// held value blanks that a later byte flushes, and a backslash left
		// pending when a stripped newline ends the line.
		line_q = '{CH_SPACE, CH_TAB, 8'h6B, CH_BSLASH, CH_HASH, CH_SPACE, CH_TAB, 8'h76,
			CH_SPACE, CH_TAB, 8'h77, CH_BSLASH, CH_NEWLINE};
		send_line();
		// Extreme byte values, a newline inside the line, a zero byte, a
		// backslash that escapes nothing, and a comment after the name.
		line_q = '{8'h01, 8'hFF, CH_NEWLINE, CH_NUL, CH_BSLASH, 8'h78, CH_SPACE, CH_HASH,
			8'h7A};
		send_line();
		// A comment-only line and a line holding nothing but a newline.
		line_q = '{CH_SPACE, CH_HASH};
		send_line();
		line_q = '{CH_NEWLINE};
		send_line();

		run_phase(0, 0);
		run_phase(59, 0);
		run_phase(0, 59);
		run_phase(8, 8);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_tokens.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (board.pending_tokens.size() != 0)
				$display("%0d expected results never arrived", board.pending_tokens.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/clt_pkg.sv
hdl/clt_datapath.sv
hdl/clt_ctrl.sv
hdl/config_line_tokenizer.sv
test/tb.sv
